>>> src/flow_credit_status_tracker_core_macros.svh
// assertion macros shared by the checker
// the enclosing module must have i_clk and i_rst_n in scope
`ifndef FLOW_CREDIT_STATUS_TRACKER_CORE_MACROS_SVH
`define FLOW_CREDIT_STATUS_TRACKER_CORE_MACROS_SVH

// checked only out of reset
`define FCST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fcst check failed");

// checked on every edge, reset included
`define FCST_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("fcst check failed");

`endif

>>> src/fcst_pkg.sv
// types, constants and helpers for the flow credit status tracker
// no dependencies
package fcst_pkg;

    localparam int NUM_FLOWS          = 1024;
    localparam int MULTICAST_FLOWS    = 4;
    localparam int EMPTY_CREDIT_LIMIT = 64;
    localparam int FLOW_W             = 10;
    localparam int ADDR_W             = $clog2(NUM_FLOWS);
    localparam int AMT_W              = 16;
    localparam int CNT_W              = 32;
    localparam int CFG_IDX_W          = 4;

    typedef logic [1:0] t_func;
    localparam t_func FN_ENQ    = 2'd0;
    localparam t_func FN_DEQ    = 2'd1;
    localparam t_func FN_CREDIT = 2'd2;

    typedef enum logic [1:0] {
        ST_OFF    = 2'd0,
        ST_SLOW   = 2'd1,
        ST_NORMAL = 2'd2
    } t_status;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_BACKOFF_EXIT  = 4'd0;
    localparam t_cfg_idx REG_BACKLOG_EXIT  = 4'd1;
    localparam t_cfg_idx REG_OFF_TO_NORMAL = 4'd2;
    localparam t_cfg_idx REG_OFF_TO_SLOW   = 4'd3;
    localparam t_cfg_idx REG_SLOW_TO_NORM  = 4'd4;
    localparam t_cfg_idx REG_NORM_TO_SLOW  = 4'd5;
    localparam t_cfg_idx REG_BACKLOG_OFF   = 4'd6;
    localparam t_cfg_idx REG_BACKOFF       = 4'd7;

    typedef struct packed {
        logic [CNT_W-1:0] backoff_exit;
        logic [CNT_W-1:0] backlog_exit;
        logic [CNT_W-1:0] off_to_normal;
        logic [CNT_W-1:0] off_to_slow;
        logic [CNT_W-1:0] slow_to_normal;
        logic [CNT_W-1:0] normal_to_slow;
        logic [CNT_W-1:0] backlog_off;
        logic [CNT_W-1:0] backoff;
    } t_limits;

    // one memory word per flow
    typedef struct packed {
        logic [CNT_W-1:0] depth;
        logic [CNT_W-1:0] bal;
        t_status          status;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic signed [CNT_W:0] sx33(input logic [CNT_W-1:0] v);
        return $signed({v[CNT_W-1], v});
    endfunction

    // clamp a 33-bit result back to the 32-bit signed range
    function automatic logic [CNT_W-1:0] sat32(input logic [CNT_W:0] v);
        logic [CNT_W-1:0] res;
        if (v[CNT_W] != v[CNT_W-1]) begin
            res = v[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
        end else begin
            res = v[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> src/flow_credit_status_tracker_core.sv
// an accepted item is registered and its flow word is read from the per-flow memory, then
// updated in S_READ and evaluated in S_EVAL; the result strobe is registered from S_EVAL
// for unicast flows only; busy holds through this read-modify-write, so no new item is taken
// before the last one is done; after reset busy stays high while all NUM_FLOWS (1024) words are cleared
// the result strobe cannot be stalled; config writes are taken at any time
module flow_credit_status_tracker_core
    import fcst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_func,
    input  logic [FLOW_W-1:0] i_flow,
    input  logic [AMT_W-1:0] i_amount,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_valid,
    output logic [FLOW_W-1:0] o_out_flow,
    output logic [1:0]       o_status,
    output logic             o_status_changed
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    t_func             r_func;
    logic [FLOW_W-1:0] r_flow;
    logic [AMT_W-1:0]  r_amount;
    logic              r_flow_ok;
    logic [CNT_W-1:0]  r_depth;
    logic [CNT_W-1:0]  r_bal;
    t_status           r_old;
    logic              r_valid;
    logic [FLOW_W-1:0] r_out_flow;
    t_status           r_status;
    logic              r_changed;

    t_limits           limits;
    t_entry            rd_entry;
    t_entry            wr_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic [CNT_W-1:0]  upd_depth;
    logic [CNT_W-1:0]  upd_bal;
    t_status           next_status;
    logic              accept;
    logic              func_ok;
    logic              unicast;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign func_ok = (r_func == FN_ENQ) || (r_func == FN_DEQ) || (r_func == FN_CREDIT);
    assign unicast = !(r_flow < FLOW_W'(MULTICAST_FLOWS));
    assign rd_entry = t_entry'(rd_word);

    fcst_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_limits   (limits)
    );

    fcst_update u_update (
        .i_func   (r_func),
        .i_amount (r_amount),
        .i_depth  (rd_entry.depth),
        .i_bal    (rd_entry.bal),
        .o_depth  (upd_depth),
        .o_bal    (upd_bal)
    );

    fcst_eval u_eval (
        .i_old    (r_old),
        .i_depth  (r_depth),
        .i_bal    (r_bal),
        .i_limits (limits),
        .o_next   (next_status)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(r_flow);
        wr_entry  = '0;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
        end else if (r_state == S_EVAL && func_ok && r_flow_ok) begin
            mem_we         = 1'b1;
            wr_entry.depth = r_depth;
            wr_entry.bal   = r_bal;
            // multicast flows keep their status untouched
            wr_entry.status = unicast ? next_status : r_old;
        end
    end

    fcst_ram #(
        .DEPTH (NUM_FLOWS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_entry),
        .i_re    (accept),
        .i_raddr (ADDR_W'(i_flow)),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= (r_state == S_EVAL) && func_ok && r_flow_ok && unicast;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(NUM_FLOWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state   <= S_READ;
                        r_func    <= t_func'(i_func);
                        r_flow    <= i_flow;
                        r_amount  <= i_amount;
                        r_flow_ok <= ({1'b0, i_flow} < (FLOW_W + 1)'(NUM_FLOWS));
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                    r_depth <= upd_depth;
                    r_bal   <= upd_bal;
                    r_old   <= rd_entry.status;
                end
                S_EVAL: begin
                    r_state    <= S_IDLE;
                    r_out_flow <= r_flow;
                    r_status   <= next_status;
                    r_changed  <= (next_status != r_old);
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_out_flow       = r_out_flow;
    assign o_status         = r_status;
    assign o_status_changed = r_changed;

endmodule

>>> src/fcst_cfg.sv
// threshold register file, written through the plain config port
// depends on fcst_pkg
module fcst_cfg
    import fcst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CNT_W-1:0] i_cfg_data,
    output t_limits          o_limits
);

    t_limits r_limits;
    t_limits n_limits;

    always_comb begin
        n_limits = r_limits;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BACKOFF_EXIT:  n_limits.backoff_exit   = i_cfg_data;
                REG_BACKLOG_EXIT:  n_limits.backlog_exit   = i_cfg_data;
                REG_OFF_TO_NORMAL: n_limits.off_to_normal  = i_cfg_data;
                REG_OFF_TO_SLOW:   n_limits.off_to_slow    = i_cfg_data;
                REG_SLOW_TO_NORM:  n_limits.slow_to_normal = i_cfg_data;
                REG_NORM_TO_SLOW:  n_limits.normal_to_slow = i_cfg_data;
                REG_BACKLOG_OFF:   n_limits.backlog_off    = i_cfg_data;
                REG_BACKOFF:       n_limits.backoff        = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits <= '0;
        end else begin
            r_limits <= n_limits;
        end
    end

    assign o_limits = r_limits;

endmodule

>>> src/fcst_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module fcst_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 66,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fcst_update.sv
// saturating depth and balance update for one event
// depends on fcst_pkg
module fcst_update
    import fcst_pkg::*;
(
    input  t_func            i_func,
    input  logic [AMT_W-1:0] i_amount,
    input  logic [CNT_W-1:0] i_depth,
    input  logic [CNT_W-1:0] i_bal,
    output logic [CNT_W-1:0] o_depth,
    output logic [CNT_W-1:0] o_bal
);

    logic signed [CNT_W:0] amt;
    logic signed [CNT_W:0] d;
    logic signed [CNT_W:0] b;

    always_comb begin
        amt = $signed({{(CNT_W + 1 - AMT_W){1'b0}}, i_amount});
        d   = sx33(i_depth);
        b   = sx33(i_bal);
        o_depth = i_depth;
        o_bal   = i_bal;
        case (i_func)
            FN_ENQ: begin
                o_depth = sat32(d + amt);
            end
            FN_DEQ: begin
                o_depth = sat32(d - amt);
                o_bal   = sat32(b - amt);
            end
            FN_CREDIT: begin
                o_bal = sat32(b + amt);
            end
            default: ;
        endcase
    end

endmodule

>>> src/fcst_eval.sv
// off/slow/normal request status evaluation against the thresholds
// depends on fcst_pkg
module fcst_eval
    import fcst_pkg::*;
(
    input  t_status          i_old,
    input  logic [CNT_W-1:0] i_depth,
    input  logic [CNT_W-1:0] i_bal,
    input  t_limits          i_limits,
    output t_status          o_next
);

    localparam logic [CNT_W-1:0] EMPTY_LIM = CNT_W'(EMPTY_CREDIT_LIMIT);

    logic signed [CNT_W:0] d;
    logic signed [CNT_W:0] b;
    logic signed [CNT_W:0] dmb;
    logic signed [CNT_W:0] bmd;
    logic                  can_leave_off;

    always_comb begin
        d   = sx33(i_depth);
        b   = sx33(i_bal);
        dmb = d - b;
        bmd = b - d;
        can_leave_off = (d > 0) && (b < sx33(i_limits.backoff_exit))
                        && (bmd < sx33(i_limits.backlog_exit));
        o_next = i_old;
        case (i_old)
            ST_OFF: begin
                if (can_leave_off && dmb > sx33(i_limits.off_to_normal)) begin
                    o_next = ST_NORMAL;
                end else if (can_leave_off && dmb > sx33(i_limits.off_to_slow)) begin
                    o_next = ST_SLOW;
                end
            end
            default: begin
                if (i_old == ST_SLOW && dmb > sx33(i_limits.slow_to_normal)) begin
                    o_next = ST_NORMAL;
                end else if (i_old != ST_SLOW && dmb < sx33(i_limits.normal_to_slow)) begin
                    o_next = ST_SLOW;
                end else if (d == 0) begin
                    // empty queue: drop out only once enough credit piled up
                    if (b >= sx33(EMPTY_LIM)) begin
                        o_next = ST_OFF;
                    end
                end else if (bmd >= sx33(i_limits.backlog_off)) begin
                    o_next = ST_OFF;
                end else if (b >= sx33(i_limits.backoff)) begin
                    o_next = ST_OFF;
                end
            end
        endcase
    end

endmodule

>>> src/fcst_checker.sv
// port-level checks on the tracker top level, bound in below
// depends on fcst_pkg and flow_credit_status_tracker_core_macros.svh
`include "flow_credit_status_tracker_core_macros.svh"

module fcst_checker
    import fcst_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [1:0]        o_status,
    input logic              o_status_changed
);

    // an accepted item holds the block busy on the next cycle
    `FCST_ASSERT(a_accept_busy, start && !busy |=> busy)
    // a result only shows once the block is free again
    `FCST_ASSERT(a_valid_idle, o_valid |-> !busy)
    // each item passes through S_READ and S_EVAL before the block is free, so strobes never come back to back
    `FCST_ASSERT_ALWAYS(a_valid_gap, o_valid |=> !o_valid)
    // reset starts the clear pass with no result pending
    `FCST_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> busy && !o_valid)
    // a status message carries a known flag and a defined status code
    `FCST_ASSERT(a_status_code, o_valid |-> !$isunknown(o_status_changed) && (o_status == ST_OFF || o_status == ST_SLOW || o_status == ST_NORMAL))

endmodule

bind flow_credit_status_tracker_core fcst_checker u_fcst_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_status_changed (o_status_changed)
);
